>>> rtl/chfc_pkg.sv
package chfc_pkg;

  // control from the beat stage into the recogniser core
  typedef struct packed {
    logic byte_en;
    logic end_en;
  } step_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [6:0] count;
  } tail_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2a;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_512  = 2'd1;
  localparam logic [1:0] KIND_256  = 2'd2;

  localparam logic [6:0] LEN_512     = 7'd86;
  localparam logic [6:0] LEN_256     = 7'd43;
  localparam logic [6:0] YES_SALT_MAX = 7'd86;
  localparam logic [6:0] YES_HASH_LEN = 7'd43;
  localparam logic [6:0] SHA_SALT_MAX = 7'd16;
  localparam logic [6:0] MD5_SALT_MAX = 7'd8;
  localparam logic [6:0] MD5_HASH_LEN = 7'd22;
  localparam logic [5:0] BC_HASH_LEN  = 6'd53;
  localparam logic [5:0] BC_COST_LEN  = 6'd2;
  localparam logic [6:0] SR_DIGIT_MAX = 7'd8;
  localparam logic [6:0] SR_DIGIT_MIN = 7'd3;
  localparam logic [3:0] DES_LEN      = 4'd13;

  localparam logic [2:0] DEAD3 = 3'd7;
  localparam logic [3:0] DEAD4 = 4'd15;

  localparam logic [2:0] YES_START  = 3'd0;
  localparam logic [2:0] YES_Y      = 3'd1;
  localparam logic [2:0] YES_SEP    = 3'd2;
  localparam logic [2:0] YES_PARAM0 = 3'd3;
  localparam logic [2:0] YES_PARAM  = 3'd4;
  localparam logic [2:0] YES_SALT   = 3'd5;
  localparam logic [2:0] YES_HASH   = 3'd6;

  localparam logic [2:0] BC_START   = 3'd0;
  localparam logic [2:0] BC_TWO     = 3'd1;
  localparam logic [2:0] BC_VARIANT = 3'd2;
  localparam logic [2:0] BC_SEP     = 3'd3;
  localparam logic [2:0] BC_COST    = 3'd4;
  localparam logic [2:0] BC_HASH    = 3'd5;

  localparam logic [2:0] SP_START = 3'd0;
  localparam logic [2:0] SP_KIND  = 3'd1;
  localparam logic [2:0] SP_SEP   = 3'd2;
  localparam logic [2:0] SP_SALT  = 3'd3;
  localparam logic [2:0] SP_HASH  = 3'd4;

  localparam logic [3:0] SR_START     = 4'd0;
  localparam logic [3:0] SR_KIND      = 4'd1;
  localparam logic [3:0] SR_SEP       = 4'd2;
  localparam logic [3:0] SR_LIT_FIRST = 4'd3;
  localparam logic [3:0] SR_LIT_LAST  = 4'd9;
  localparam logic [3:0] SR_LEAD      = 4'd10;
  localparam logic [3:0] SR_DIGITS    = 4'd11;
  localparam logic [3:0] SR_SALT      = 4'd12;
  localparam logic [3:0] SR_HASH      = 4'd13;

  localparam logic [2:0] MD_START = 3'd0;
  localparam logic [2:0] MD_ONE   = 3'd1;
  localparam logic [2:0] MD_SEP   = 3'd2;
  localparam logic [2:0] MD_SALT  = 3'd3;
  localparam logic [2:0] MD_HASH  = 3'd4;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_cls(input logic [7:0] c);
    return (c == ".") || (c == "/") || ((c >= "A") && (c <= "Z")) ||
           ((c >= "a") && (c <= "z")) || is_digit(c);
  endfunction

  function automatic logic is_salt(input logic [7:0] c);
    return (c != CH_DOLLAR) && (c != CH_COLON) && (c != CH_NL);
  endfunction

  function automatic logic [6:0] sha_hash_len(input logic [1:0] kind);
    logic [6:0] len;
    case (kind)
      KIND_512: len = LEN_512;
      KIND_256: len = LEN_256;
      default:  len = 7'd0;
    endcase
    return len;
  endfunction

  // expected byte of the literal rounds= at a given phase
  function automatic logic [7:0] rounds_lit(input logic [3:0] ph);
    logic [7:0] c;
    case (ph)
      4'd3:    c = "r";
      4'd4:    c = "o";
      4'd5:    c = "u";
      4'd6:    c = "n";
      4'd7:    c = "d";
      4'd8:    c = "s";
      default: c = "=";
    endcase
    return c;
  endfunction

  // salt run, then '$', then a fixed-length hash run
  function automatic tail_t tail_step(input logic [3:0] ph, input logic [6:0] cnt,
                                      input logic [3:0] salt_ph, input logic [3:0] dead,
                                      input logic [6:0] smax, input logic [6:0] hlen,
                                      input logic salt_cls, input logic [7:0] c);
    tail_t r;
    logic in_set;
    r.phase = ph;
    r.count = cnt;
    in_set  = salt_cls ? is_cls(c) : is_salt(c);
    if (ph == salt_ph) begin
      if ((c == CH_DOLLAR) && (cnt != 7'd0)) begin
        r.phase = salt_ph + 4'd1;
        r.count = 7'd0;
      end else if (in_set && (cnt < smax)) begin
        r.count = cnt + 7'd1;
      end else begin
        r.phase = dead;
      end
    end else if (is_cls(c) && (cnt < hlen)) begin
      r.count = cnt + 7'd1;
    end else begin
      r.phase = dead;
    end
    return r;
  endfunction

endpackage

>>> rtl/chfc_if.sv
interface chfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_end;

  modport source (output valid, output ch, output is_end, input ready);
  modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface chfc_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

>>> rtl/chfc_core.sv
module chfc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  chfc_pkg::step_t  step,
  input  logic [7:0]       ch,
  output logic             ok
);

  logic       first_pending_r, first_pending_nxt;
  logic [1:0] body_length_r, body_length_nxt;
  logic       star_only_r, star_only_nxt;
  logic [2:0] yes_phase_r, yes_phase_nxt;
  logic [6:0] yes_count_r, yes_count_nxt;
  logic [2:0] bc_phase_r, bc_phase_nxt;
  logic [5:0] bc_count_r, bc_count_nxt;
  logic [1:0] sha_kind_r, sha_kind_nxt;
  logic [2:0] sp_phase_r, sp_phase_nxt;
  logic [6:0] sp_count_r, sp_count_nxt;
  logic [3:0] sr_phase_r, sr_phase_nxt;
  logic [6:0] sr_count_r, sr_count_nxt;
  logic [2:0] md_phase_r, md_phase_nxt;
  logic [4:0] md_count_r, md_count_nxt;
  logic [3:0] des_count_r, des_count_nxt;
  logic       des_dead_r, des_dead_nxt;

  logic [6:0]      hl;
  chfc_pkg::tail_t yes_t, sp_t, sr_t, md_t;

  assign hl = chfc_pkg::sha_hash_len(sha_kind_r);

  assign yes_t = chfc_pkg::tail_step({1'b0, yes_phase_r}, yes_count_r,
                                     {1'b0, chfc_pkg::YES_SALT}, {1'b0, chfc_pkg::DEAD3},
                                     chfc_pkg::YES_SALT_MAX, chfc_pkg::YES_HASH_LEN,
                                     1'b1, ch);
  assign sp_t  = chfc_pkg::tail_step({1'b0, sp_phase_r}, sp_count_r,
                                     {1'b0, chfc_pkg::SP_SALT}, {1'b0, chfc_pkg::DEAD3},
                                     chfc_pkg::SHA_SALT_MAX, hl, 1'b0, ch);
  assign sr_t  = chfc_pkg::tail_step(sr_phase_r, sr_count_r, chfc_pkg::SR_SALT,
                                     chfc_pkg::DEAD4, chfc_pkg::SHA_SALT_MAX, hl, 1'b0, ch);
  assign md_t  = chfc_pkg::tail_step({1'b0, md_phase_r}, {2'b00, md_count_r},
                                     {1'b0, chfc_pkg::MD_SALT}, {1'b0, chfc_pkg::DEAD3},
                                     chfc_pkg::MD5_SALT_MAX, chfc_pkg::MD5_HASH_LEN,
                                     1'b0, ch);

  always_comb begin
    ok = (body_length_r == 2'd0) ||
         ((body_length_r == 2'd1) && star_only_r) ||
         ((yes_phase_r == chfc_pkg::YES_HASH) && (yes_count_r == chfc_pkg::YES_HASH_LEN)) ||
         ((bc_phase_r == chfc_pkg::BC_HASH) && (bc_count_r == chfc_pkg::BC_HASH_LEN)) ||
         ((hl != 7'd0) && (sp_phase_r == chfc_pkg::SP_HASH) && (sp_count_r == hl)) ||
         ((hl != 7'd0) && (sr_phase_r == chfc_pkg::SR_HASH) && (sr_count_r == hl)) ||
         ((md_phase_r == chfc_pkg::MD_HASH) && (md_count_r == chfc_pkg::MD5_HASH_LEN[4:0])) ||
         (!des_dead_r && (des_count_r == chfc_pkg::DES_LEN));
  end

  always_comb begin
    first_pending_nxt = first_pending_r;
    body_length_nxt   = body_length_r;
    star_only_nxt     = star_only_r;
    yes_phase_nxt     = yes_phase_r;
    yes_count_nxt     = yes_count_r;
    bc_phase_nxt      = bc_phase_r;
    bc_count_nxt      = bc_count_r;
    sha_kind_nxt      = sha_kind_r;
    sp_phase_nxt      = sp_phase_r;
    sp_count_nxt      = sp_count_r;
    sr_phase_nxt      = sr_phase_r;
    sr_count_nxt      = sr_count_r;
    md_phase_nxt      = md_phase_r;
    md_count_nxt      = md_count_r;
    des_count_nxt     = des_count_r;
    des_dead_nxt      = des_dead_r;

    if (step.end_en) begin
      first_pending_nxt = 1'b1;
      body_length_nxt   = 2'd0;
      star_only_nxt     = 1'b0;
      yes_phase_nxt     = chfc_pkg::YES_START;
      yes_count_nxt     = 7'd0;
      bc_phase_nxt      = chfc_pkg::BC_START;
      bc_count_nxt      = 6'd0;
      sha_kind_nxt      = chfc_pkg::KIND_NONE;
      sp_phase_nxt      = chfc_pkg::SP_START;
      sp_count_nxt      = 7'd0;
      sr_phase_nxt      = chfc_pkg::SR_START;
      sr_count_nxt      = 7'd0;
      md_phase_nxt      = chfc_pkg::MD_START;
      md_count_nxt      = 5'd0;
      des_count_nxt     = 4'd0;
      des_dead_nxt      = 1'b0;
    end else if (step.byte_en) begin
      first_pending_nxt = 1'b0;
      // a bang as the very first byte is dropped
      if (!(first_pending_r && (ch == chfc_pkg::CH_BANG))) begin
        if (body_length_r == 2'd0) star_only_nxt = (ch == chfc_pkg::CH_STAR);
        if (body_length_r != 2'd2) body_length_nxt = body_length_r + 2'd1;

        if (sp_phase_r == chfc_pkg::SP_KIND) begin
          if (ch == "6")      sha_kind_nxt = chfc_pkg::KIND_512;
          else if (ch == "5") sha_kind_nxt = chfc_pkg::KIND_256;
          else                sha_kind_nxt = chfc_pkg::KIND_NONE;
        end

        // yescrypt
        unique case (yes_phase_r)
          chfc_pkg::YES_START:
            yes_phase_nxt = (ch == chfc_pkg::CH_DOLLAR) ? chfc_pkg::YES_Y : chfc_pkg::DEAD3;
          chfc_pkg::YES_Y:
            yes_phase_nxt = (ch == "y") ? chfc_pkg::YES_SEP : chfc_pkg::DEAD3;
          chfc_pkg::YES_SEP:
            yes_phase_nxt = (ch == chfc_pkg::CH_DOLLAR) ? chfc_pkg::YES_PARAM0
                                                        : chfc_pkg::DEAD3;
          chfc_pkg::YES_PARAM0:
            yes_phase_nxt = chfc_pkg::is_cls(ch) ? chfc_pkg::YES_PARAM : chfc_pkg::DEAD3;
          chfc_pkg::YES_PARAM: begin
            if (!chfc_pkg::is_cls(ch)) begin
              if (ch == chfc_pkg::CH_DOLLAR) begin
                yes_phase_nxt = chfc_pkg::YES_SALT;
                yes_count_nxt = 7'd0;
              end else begin
                yes_phase_nxt = chfc_pkg::DEAD3;
              end
            end
          end
          chfc_pkg::YES_SALT, chfc_pkg::YES_HASH: begin
            yes_phase_nxt = yes_t.phase[2:0];
            yes_count_nxt = yes_t.count;
          end
          default: yes_phase_nxt = chfc_pkg::DEAD3;
        endcase

        // bcrypt
        unique case (bc_phase_r)
          chfc_pkg::BC_START:
            bc_phase_nxt = (ch == chfc_pkg::CH_DOLLAR) ? chfc_pkg::BC_TWO : chfc_pkg::DEAD3;
          chfc_pkg::BC_TWO:
            bc_phase_nxt = (ch == "2") ? chfc_pkg::BC_VARIANT : chfc_pkg::DEAD3;
          chfc_pkg::BC_VARIANT:
            bc_phase_nxt = ((ch == "a") || (ch == "b") || (ch == "x") || (ch == "y"))
                           ? chfc_pkg::BC_SEP : chfc_pkg::DEAD3;
          chfc_pkg::BC_SEP: begin
            bc_phase_nxt = (ch == chfc_pkg::CH_DOLLAR) ? chfc_pkg::BC_COST : chfc_pkg::DEAD3;
            bc_count_nxt = 6'd0;
          end
          chfc_pkg::BC_COST: begin
            if (chfc_pkg::is_digit(ch) && (bc_count_r < chfc_pkg::BC_COST_LEN)) begin
              bc_count_nxt = bc_count_r + 6'd1;
            end else if ((ch == chfc_pkg::CH_DOLLAR) &&
                         (bc_count_r == chfc_pkg::BC_COST_LEN)) begin
              bc_phase_nxt = chfc_pkg::BC_HASH;
              bc_count_nxt = 6'd0;
            end else begin
              bc_phase_nxt = chfc_pkg::DEAD3;
            end
          end
          chfc_pkg::BC_HASH: begin
            if (chfc_pkg::is_cls(ch) && (bc_count_r < chfc_pkg::BC_HASH_LEN))
              bc_count_nxt = bc_count_r + 6'd1;
            else
              bc_phase_nxt = chfc_pkg::DEAD3;
          end
          default: bc_phase_nxt = chfc_pkg::DEAD3;
        endcase

        // sha without rounds=
        unique case (sp_phase_r)
          chfc_pkg::SP_START:
            sp_phase_nxt = (ch == chfc_pkg::CH_DOLLAR) ? chfc_pkg::SP_KIND : chfc_pkg::DEAD3;
          chfc_pkg::SP_KIND:
            sp_phase_nxt = ((ch == "5") || (ch == "6")) ? chfc_pkg::SP_SEP : chfc_pkg::DEAD3;
          chfc_pkg::SP_SEP: begin
            sp_phase_nxt = (ch == chfc_pkg::CH_DOLLAR) ? chfc_pkg::SP_SALT : chfc_pkg::DEAD3;
            sp_count_nxt = 7'd0;
          end
          chfc_pkg::SP_SALT, chfc_pkg::SP_HASH: begin
            sp_phase_nxt = sp_t.phase[2:0];
            sp_count_nxt = sp_t.count;
          end
          default: sp_phase_nxt = chfc_pkg::DEAD3;
        endcase

        // sha with rounds=
        unique case (sr_phase_r) inside
          chfc_pkg::SR_START:
            sr_phase_nxt = (ch == chfc_pkg::CH_DOLLAR) ? chfc_pkg::SR_KIND : chfc_pkg::DEAD4;
          chfc_pkg::SR_KIND:
            sr_phase_nxt = ((ch == "5") || (ch == "6")) ? chfc_pkg::SR_SEP : chfc_pkg::DEAD4;
          chfc_pkg::SR_SEP:
            sr_phase_nxt = (ch == chfc_pkg::CH_DOLLAR) ? chfc_pkg::SR_LIT_FIRST
                                                       : chfc_pkg::DEAD4;
          [chfc_pkg::SR_LIT_FIRST:chfc_pkg::SR_LIT_LAST]:
            sr_phase_nxt = (ch == chfc_pkg::rounds_lit(sr_phase_r)) ? sr_phase_r + 4'd1
                                                                     : chfc_pkg::DEAD4;
          chfc_pkg::SR_LEAD: begin
            sr_phase_nxt = ((ch >= "1") && (ch <= "9")) ? chfc_pkg::SR_DIGITS
                                                        : chfc_pkg::DEAD4;
            sr_count_nxt = 7'd0;
          end
          chfc_pkg::SR_DIGITS: begin
            if (chfc_pkg::is_digit(ch) && (sr_count_r < chfc_pkg::SR_DIGIT_MAX)) begin
              sr_count_nxt = sr_count_r + 7'd1;
            end else if ((ch == chfc_pkg::CH_DOLLAR) &&
                         (sr_count_r >= chfc_pkg::SR_DIGIT_MIN)) begin
              sr_phase_nxt = chfc_pkg::SR_SALT;
              sr_count_nxt = 7'd0;
            end else begin
              sr_phase_nxt = chfc_pkg::DEAD4;
            end
          end
          chfc_pkg::SR_SALT, chfc_pkg::SR_HASH: begin
            sr_phase_nxt = sr_t.phase;
            sr_count_nxt = sr_t.count;
          end
          default: sr_phase_nxt = chfc_pkg::DEAD4;
        endcase

        // md5
        unique case (md_phase_r)
          chfc_pkg::MD_START:
            md_phase_nxt = (ch == chfc_pkg::CH_DOLLAR) ? chfc_pkg::MD_ONE : chfc_pkg::DEAD3;
          chfc_pkg::MD_ONE:
            md_phase_nxt = (ch == "1") ? chfc_pkg::MD_SEP : chfc_pkg::DEAD3;
          chfc_pkg::MD_SEP: begin
            md_phase_nxt = (ch == chfc_pkg::CH_DOLLAR) ? chfc_pkg::MD_SALT : chfc_pkg::DEAD3;
            md_count_nxt = 5'd0;
          end
          chfc_pkg::MD_SALT, chfc_pkg::MD_HASH: begin
            md_phase_nxt = md_t.phase[2:0];
            md_count_nxt = md_t.count[4:0];
          end
          default: md_phase_nxt = chfc_pkg::DEAD3;
        endcase

        // des
        if (!des_dead_r && chfc_pkg::is_cls(ch) && (des_count_r < chfc_pkg::DES_LEN))
          des_count_nxt = des_count_r + 4'd1;
        else
          des_dead_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pending_r <= 1'b1;
      body_length_r   <= 2'd0;
      star_only_r     <= 1'b0;
      yes_phase_r     <= chfc_pkg::YES_START;
      yes_count_r     <= 7'd0;
      bc_phase_r      <= chfc_pkg::BC_START;
      bc_count_r      <= 6'd0;
      sha_kind_r      <= chfc_pkg::KIND_NONE;
      sp_phase_r      <= chfc_pkg::SP_START;
      sp_count_r      <= 7'd0;
      sr_phase_r      <= chfc_pkg::SR_START;
      sr_count_r      <= 7'd0;
      md_phase_r      <= chfc_pkg::MD_START;
      md_count_r      <= 5'd0;
      des_count_r     <= 4'd0;
      des_dead_r      <= 1'b0;
    end else begin
      first_pending_r <= first_pending_nxt;
      body_length_r   <= body_length_nxt;
      star_only_r     <= star_only_nxt;
      yes_phase_r     <= yes_phase_nxt;
      yes_count_r     <= yes_count_nxt;
      bc_phase_r      <= bc_phase_nxt;
      bc_count_r      <= bc_count_nxt;
      sha_kind_r      <= sha_kind_nxt;
      sp_phase_r      <= sp_phase_nxt;
      sp_count_r      <= sp_count_nxt;
      sr_phase_r      <= sr_phase_nxt;
      sr_count_r      <= sr_count_nxt;
      md_phase_r      <= md_phase_nxt;
      md_count_r      <= md_count_nxt;
      des_count_r     <= des_count_nxt;
      des_dead_r      <= des_dead_nxt;
    end
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step.end_en |=> (first_pending_r && (body_length_r == 2'd0) && !des_dead_r))
    else $error("state not cleared after end beat");

  a_body_sat: assert property (@(posedge clk) disable iff (!rst_n)
    body_length_r != 2'd3)
    else $error("body length ran past saturation");

  a_des_bound: assert property (@(posedge clk) disable iff (!rst_n)
    des_count_r <= chfc_pkg::DES_LEN)
    else $error("des count past its length");

  a_bc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bc_count_r <= chfc_pkg::BC_HASH_LEN)
    else $error("bcrypt count past its length");

  a_kind_once: assert property (@(posedge clk) disable iff (!rst_n)
    (step.byte_en && (sp_phase_r != chfc_pkg::SP_KIND)) |=> $stable(sha_kind_r))
    else $error("sha kind changed outside the kind byte");

endmodule

>>> rtl/crypt_hash_format_checker.sv
// an end beat passes the beat stage, then its result is registered and offered
// throughput: one beat per cycle; an end beat stalls only while the previous
// result still sits unread in the result register
// reset: synchronous active-low rst_n empties the beat stage and result register
// and returns every recogniser to its start phase
module crypt_hash_format_checker (
  input  logic            clk,
  input  logic            rst_n,
  chfc_in_if.sink         in_chan,
  chfc_out_if.source      out_chan
);

  logic            stg_valid_r;
  logic [7:0]      stg_ch_r;
  logic            stg_end_r;
  logic            out_valid_r;
  logic            out_res_r;
  logic            advance;
  logic            ok;
  chfc_pkg::step_t step;

  // an end beat needs room in the result register
  assign advance = stg_valid_r && (!stg_end_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !stg_valid_r || advance;

  assign step.byte_en = advance && !stg_end_r;
  assign step.end_en  = advance && stg_end_r;

  chfc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ch    (stg_ch_r),
    .ok    (ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) stg_valid_r <= in_chan.valid;
      if (step.end_en)
        out_valid_r <= 1'b1;
      else if (out_chan.ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      stg_ch_r  <= in_chan.ch;
      stg_end_r <= in_chan.is_end;
    end
    if (step.end_en) out_res_r <= ok;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.valid_res = out_res_r;

endmodule
